FILE: rtl/dfs_maze_carver_macros.svh
// Assertion macros shared by the maze carver RTL.
`ifndef DFS_MAZE_CARVER_MACROS_SVH
`define DFS_MAZE_CARVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define DMC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define DMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dmc_pkg.sv
// Shared types, codes and the direction shuffle of the maze carver.
package dmc_pkg;

	localparam int DEF_MAX_COLUMNS = 32;
	localparam int DEF_MAX_ROWS    = 16;

	// configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 6;
	localparam int COLS_REG_W  = 6;
	localparam int ROWS_REG_W  = 5;
	localparam int CMP_W       = 7;	// holds any register value and any grid maximum
	localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_USED = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS_USED    = 1'd1;
	localparam logic [COLS_REG_W-1:0]  COLS_RESET = 6'd10;
	localparam logic [ROWS_REG_W-1:0]  ROWS_RESET = 5'd7;

	// stream fields
	localparam int ORG_COL_W   = 5;
	localparam int ORG_ROW_W   = 4;
	localparam int PICK_W      = 2;
	localparam int CELL_COL_W  = 5;
	localparam int CELL_ROW_W  = 4;
	localparam int DIR_W       = 2;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 16;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef enum logic [1:0] {
		EV_START     = 2'd0,
		EV_CARVE     = 2'd1,
		EV_BACKTRACK = 2'd2,
		EV_IDLE      = 2'd3
	} ev_t;

	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

	typedef logic [3:0][DIR_W-1:0] dir_order_t;

	typedef struct packed {
		logic             found;
		logic [DIR_W-1:0] dir;
	} pick_t;

	// Swap slot i with slot pick_i in turn; a pick below its slot leaves the slot alone.
	function automatic dir_order_t shuffle_dirs(input logic [PICK_W-1:0] p0,
			input logic [PICK_W-1:0] p1, input logic [PICK_W-1:0] p2);
		dir_order_t         d;
		logic [DIR_W-1:0]   t;
		logic [PICK_W-1:0]  j1;
		logic [PICK_W-1:0]  j2;
		d[0] = DIR_UP;
		d[1] = DIR_RIGHT;
		d[2] = DIR_DOWN;
		d[3] = DIR_LEFT;
		t     = d[0];
		d[0]  = d[p0];
		d[p0] = t;
		j1    = (p1 < 2'd1) ? 2'd1 : p1;
		t     = d[1];
		d[1]  = d[j1];
		d[j1] = t;
		j2    = (p2 < 2'd2) ? 2'd2 : p2;
		t     = d[2];
		d[2]  = d[j2];
		d[j2] = t;
		return d;
	endfunction

endpackage

FILE: rtl/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/dmc_pick.sv
// Direction shuffle and first open neighbor selection for one carving step.
module dmc_pick import dmc_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	localparam int COL_W = $clog2(MAX_COLUMNS),
	localparam int ROW_W = $clog2(MAX_ROWS),
	localparam int EC_W  = $clog2(MAX_COLUMNS + 1),
	localparam int ER_W  = $clog2(MAX_ROWS + 1)
) (
	input  logic [PICK_W-1:0]      pick_first,
	input  logic [PICK_W-1:0]      pick_second,
	input  logic [PICK_W-1:0]      pick_third,
	input  logic [COL_W-1:0]       col,
	input  logic [ROW_W-1:0]       row,
	input  logic [EC_W-1:0]        cols_eff,
	input  logic [ER_W-1:0]        rows_eff,
	input  logic [MAX_COLUMNS-1:0] word_up,
	input  logic [MAX_COLUMNS-1:0] word_mid,
	input  logic [MAX_COLUMNS-1:0] word_dn,
	output pick_t                  choice
);

	dir_order_t       order;
	logic [3:0]       open;
	logic [COL_W-1:0] col_nx;
	logic [COL_W-1:0] col_pv;

	assign order  = shuffle_dirs(pick_first, pick_second, pick_third);
	assign col_nx = col + 1'b1;
	assign col_pv = col - 1'b1;

	// a neighbor is open when it lies in the current grid and is not yet visited
	always_comb begin
		open[DIR_UP]    = (row != '0) && ((ER_W'(row) - 1'b1) < rows_eff) && !word_up[col];
		open[DIR_RIGHT] = ((EC_W'(col) + 1'b1) < cols_eff) && !word_mid[col_nx];
		open[DIR_DOWN]  = ((ER_W'(row) + 1'b1) < rows_eff) && !word_dn[col];
		open[DIR_LEFT]  = (col != '0) && ((EC_W'(col) - 1'b1) < cols_eff) && !word_mid[col_pv];
	end

	// take the first open direction in shuffled order
	always_comb begin
		choice = '0;
		for (int i = 3; i >= 0; i--) begin
			if (open[order[i]]) begin
				choice.found = 1'b1;
				choice.dir   = order[i];
			end
		end
	end

endmodule

FILE: rtl/dfs_maze_carver.sv
// Top level of the depth-first maze carver: stream ports, stages, stack and visited map.
//
// Depth-first (recursive backtracker) maze carver. A start item (tuser 0) clears the visited
// map and pushes the origin cell, clamped into the grid; each step item (tuser 1) shuffles
// the four directions with its three swap picks, then carves toward the first in-grid,
// unvisited neighbor of the stack top or pops it. Every input item yields exactly one
// result item: started, carved (with the wall direction), backtracked (tlast set when
// the stack has just emptied) or ignored while idle. Stage 2 holds one item at a time:
// an item issues its reads only once the one before has left stage 2. Stage 1 issues
// the reads of the three visited-map rows around the top cell and of the stack entry
// under the top; stage 2 decides and writes the map, the stack and the top-cell
// register, and the next item may only read after those writes land. An item passes
// from the input register through stage 2 into the output register, and may wait in
// the input register while the one before is still in stage 2 or the output stalls.
// The input register accepts a new item while another is in flight and the output
// register holds a result until it is taken. The visited map is stored one row per word
// with a valid flag per row, so a start clears it at once: no clearing pass after reset.
// Configuration writes are taken at any time but belong only to idle periods.
`include "dfs_maze_carver_macros.svh"

module dfs_maze_carver import dmc_pkg::*; #(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// origin_col[4:0], origin_row[8:5], pick_first[10:9], pick_second[12:11],
	// pick_third[14:13], zero[15]
	input  logic [S_TDATA_W-1:0]   s_tdata,
	// action[0]
	input  logic                   s_tuser,
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// cell_col[4:0], cell_row[8:5], carve_dir[10:9], zero[15:11]
	output logic [M_TDATA_W-1:0]   m_tdata,
	// event_kind[1:0]
	output logic [1:0]             m_tuser,
	// finished
	output logic                   m_tlast
);

	localparam int COL_W      = $clog2(MAX_COLUMNS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int EC_W       = $clog2(MAX_COLUMNS + 1);
	localparam int ER_W       = $clog2(MAX_ROWS + 1);
	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int SA_W       = $clog2(CELL_COUNT);
	localparam int DEP_W      = $clog2(CELL_COUNT + 1);
	localparam int ENT_W      = COL_W + ROW_W;

	// configuration registers and effective grid size
	logic [COLS_REG_W-1:0] cols_q;
	logic [ROWS_REG_W-1:0] rows_q;
	logic [EC_W-1:0]       cols_eff;
	logic [ER_W-1:0]       rows_eff;

	// stage 1: input register
	logic                 vld_s1;
	logic                 action_s1;
	logic [ORG_COL_W-1:0] org_col_s1;
	logic [ORG_ROW_W-1:0] org_row_s1;
	logic [PICK_W-1:0]    pick0_s1;
	logic [PICK_W-1:0]    pick1_s1;
	logic [PICK_W-1:0]    pick2_s1;

	// stage 2: decide and update
	logic                 vld_s2;
	logic                 action_s2;
	logic [ORG_COL_W-1:0] org_col_s2;
	logic [ORG_ROW_W-1:0] org_row_s2;
	logic [PICK_W-1:0]    pick0_s2;
	logic [PICK_W-1:0]    pick1_s2;
	logic [PICK_W-1:0]    pick2_s2;

	logic go_s1;
	logic done_s2;

	// carver state
	logic [DEP_W-1:0]    depth_q;
	logic [COL_W-1:0]    top_col_q;
	logic [ROW_W-1:0]    top_row_q;
	logic [MAX_ROWS-1:0] row_vld_q;

	// memories
	logic [ROW_W-1:0]       row_up;
	logic [ROW_W-1:0]       row_dn;
	logic [MAX_COLUMNS-1:0] vis_up_rd;
	logic [MAX_COLUMNS-1:0] vis_mid_rd;
	logic [MAX_COLUMNS-1:0] vis_dn_rd;
	logic [MAX_COLUMNS-1:0] word_up;
	logic [MAX_COLUMNS-1:0] word_mid;
	logic [MAX_COLUMNS-1:0] word_dn;
	logic                   vis_we;
	logic [ROW_W-1:0]       vis_waddr;
	logic [MAX_COLUMNS-1:0] vis_wdata;
	logic                   stk_we;
	logic [SA_W-1:0]        stk_waddr;
	logic [SA_W-1:0]        stk_raddr;
	logic [ENT_W-1:0]       stk_rd;

	// decision
	pick_t                  choice;
	logic                   is_start;
	logic                   is_idle;
	logic                   is_carve;
	logic [COL_W-1:0]       org_col;
	logic [ROW_W-1:0]       org_row;
	logic [COL_W-1:0]       nb_col;
	logic [ROW_W-1:0]       nb_row;
	logic [MAX_COLUMNS-1:0] nb_word;

	// result
	ev_t                   res_ev;
	logic [COL_W-1:0]      res_col;
	logic [ROW_W-1:0]      res_row;
	logic [DIR_W-1:0]      res_dir;
	logic                  res_fin;
	ev_t                   ev_q;
	logic [CELL_COL_W-1:0] col_q;
	logic [CELL_ROW_W-1:0] row_q;
	logic [DIR_W-1:0]      dir_q;
	logic                  fin_q;
	logic                  out_vld_q;

	// ---------------------------------------------------------------- configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLUMNS_USED: cols_q <= cfg_data;
				REG_ROWS_USED:    rows_q <= cfg_data[ROWS_REG_W-1:0];
				default:          ;
			endcase
		end
	end

	// zero acts as one, anything above the maximum acts as the maximum
	always_comb begin
		if (cols_q == '0) begin
			cols_eff = EC_W'(1);
		end else if (CMP_W'(cols_q) > CMP_W'(MAX_COLUMNS)) begin
			cols_eff = EC_W'(MAX_COLUMNS);
		end else begin
			cols_eff = EC_W'(cols_q);
		end
		if (rows_q == '0) begin
			rows_eff = ER_W'(1);
		end else if (CMP_W'(rows_q) > CMP_W'(MAX_ROWS)) begin
			rows_eff = ER_W'(MAX_ROWS);
		end else begin
			rows_eff = ER_W'(rows_q);
		end
	end

	// ---------------------------------------------------------------- stage control
	// Stage 1 issues its reads only into an empty stage 2, so reads always see
	// the writes of the item before.
	assign go_s1    = vld_s1 && !vld_s2;
	assign done_s2  = vld_s2 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1  <= s_tuser;
			org_col_s1 <= s_tdata[ORG_COL_W-1:0];
			org_row_s1 <= s_tdata[ORG_COL_W +: ORG_ROW_W];
			pick0_s1   <= s_tdata[ORG_COL_W + ORG_ROW_W +: PICK_W];
			pick1_s1   <= s_tdata[ORG_COL_W + ORG_ROW_W + PICK_W +: PICK_W];
			pick2_s1   <= s_tdata[ORG_COL_W + ORG_ROW_W + 2 * PICK_W +: PICK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (go_s1) begin
			vld_s2 <= 1'b1;
		end else if (done_s2) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			action_s2  <= action_s1;
			org_col_s2 <= org_col_s1;
			org_row_s2 <= org_row_s1;
			pick0_s2   <= pick0_s1;
			pick1_s2   <= pick1_s1;
			pick2_s2   <= pick2_s1;
		end
	end

	// ---------------------------------------------------------------- memories
	// Three copies of the visited map, one row per word, read at the rows above,
	// at and below the top cell; all take the same write.
	assign row_up    = top_row_q - 1'b1;
	assign row_dn    = top_row_q + 1'b1;
	assign stk_raddr = SA_W'(depth_q - DEP_W'(2));

	dmc_ram #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_vis_up (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (go_s1),
		.raddr (row_up),
		.rdata (vis_up_rd)
	);

	dmc_ram #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_vis_mid (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (go_s1),
		.raddr (top_row_q),
		.rdata (vis_mid_rd)
	);

	dmc_ram #(.WIDTH(MAX_COLUMNS), .DEPTH(MAX_ROWS)) u_vis_dn (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (go_s1),
		.raddr (row_dn),
		.rdata (vis_dn_rd)
	);

	// Stack of cells packed as {row, col}; the entry under the top is read ahead for a pop.
	dmc_ram #(.WIDTH(ENT_W), .DEPTH(CELL_COUNT)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata ({nb_row, nb_col}),
		.re    (go_s1),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	// a row not written since the last start reads as all unvisited
	assign word_up  = row_vld_q[row_up]    ? vis_up_rd  : '0;
	assign word_mid = row_vld_q[top_row_q] ? vis_mid_rd : '0;
	assign word_dn  = row_vld_q[row_dn]    ? vis_dn_rd  : '0;

	// ---------------------------------------------------------------- decision
	dmc_pick #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_pick (
		.pick_first  (pick0_s2),
		.pick_second (pick1_s2),
		.pick_third  (pick2_s2),
		.col         (top_col_q),
		.row         (top_row_q),
		.cols_eff    (cols_eff),
		.rows_eff    (rows_eff),
		.word_up     (word_up),
		.word_mid    (word_mid),
		.word_dn     (word_dn),
		.choice      (choice)
	);

	// clamp the origin to the last column and row of the grid
	always_comb begin
		if (CMP_W'(org_col_s2) >= CMP_W'(cols_eff)) begin
			org_col = COL_W'(cols_eff - 1'b1);
		end else begin
			org_col = COL_W'(org_col_s2);
		end
		if (CMP_W'(org_row_s2) >= CMP_W'(rows_eff)) begin
			org_row = ROW_W'(rows_eff - 1'b1);
		end else begin
			org_row = ROW_W'(org_row_s2);
		end
	end

	assign is_start = (action_s2 == ACT_START);
	assign is_idle  = !is_start && (depth_q == '0);
	assign is_carve = !is_start && !is_idle && choice.found
		&& (depth_q < DEP_W'(CELL_COUNT));

	// neighbor cell and the old word of its row
	always_comb begin
		nb_col  = top_col_q;
		nb_row  = top_row_q;
		nb_word = word_mid;
		case (choice.dir)
			DIR_UP: begin
				nb_row  = row_up;
				nb_word = word_up;
			end
			DIR_RIGHT: begin
				nb_col = top_col_q + 1'b1;
			end
			DIR_DOWN: begin
				nb_row  = row_dn;
				nb_word = word_dn;
			end
			DIR_LEFT: begin
				nb_col = top_col_q - 1'b1;
			end
			default: begin
				nb_col = top_col_q;
			end
		endcase
		if (is_start) begin
			nb_col  = org_col;
			nb_row  = org_row;
			nb_word = '0;
		end
	end

	assign vis_we    = done_s2 && (is_start || is_carve);
	assign vis_waddr = nb_row;
	assign vis_wdata = nb_word | (MAX_COLUMNS'(1) << nb_col);
	assign stk_we    = done_s2 && (is_start || is_carve);
	assign stk_waddr = is_start ? '0 : depth_q[SA_W-1:0];

	// result of this item
	always_comb begin
		res_ev  = EV_BACKTRACK;
		res_col = top_col_q;
		res_row = top_row_q;
		res_dir = DIR_UP;
		res_fin = 1'b0;
		if (is_start) begin
			res_ev  = EV_START;
			res_col = org_col;
			res_row = org_row;
		end else if (is_idle) begin
			res_ev  = EV_IDLE;
			res_col = '0;
			res_row = '0;
		end else if (is_carve) begin
			res_ev  = EV_CARVE;
			res_dir = choice.dir;
		end else begin
			res_fin = (depth_q == DEP_W'(1));
		end
	end

	// ---------------------------------------------------------------- state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			row_vld_q <= '0;
		end else if (done_s2) begin
			if (is_start) begin
				depth_q   <= DEP_W'(1);
				row_vld_q <= MAX_ROWS'(1) << org_row;
			end else if (is_carve) begin
				depth_q           <= depth_q + 1'b1;
				row_vld_q[nb_row] <= 1'b1;
			end else if (!is_idle) begin
				depth_q <= depth_q - 1'b1;
			end
		end
	end

	// advance the top cell: new cell on start or carve, entry below on pop
	always_ff @(posedge clk) begin
		if (done_s2) begin
			if (is_start || is_carve) begin
				top_col_q <= nb_col;
				top_row_q <= nb_row;
			end else if (!is_idle) begin
				top_col_q <= stk_rd[COL_W-1:0];
				top_row_q <= stk_rd[COL_W +: ROW_W];
			end
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_s2) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s2) begin
			ev_q  <= res_ev;
			col_q <= CELL_COL_W'(res_col);
			row_q <= CELL_ROW_W'(res_row);
			dir_q <= res_dir;
			fin_q <= res_fin;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = ev_q;
	assign m_tlast  = fin_q;
	assign m_tdata  = {(M_TDATA_W - CELL_COL_W - CELL_ROW_W - DIR_W)'(0), dir_q, row_q, col_q};

	// ---------------------------------------------------------------- assertions
	`DMC_ASSERT(a_depth_bound, 1'b1, depth_q <= DEP_W'(CELL_COUNT), "stack depth beyond capacity")
	`DMC_ASSERT(a_finish_empty, m_tvalid && m_tlast, (depth_q == '0) && (m_tuser == EV_BACKTRACK), "finished shown with a nonempty stack")
	`DMC_ASSERT(a_carve_nonempty, m_tvalid && (m_tuser == EV_CARVE), depth_q >= DEP_W'(2), "carve shown without a pushed neighbor")
	`DMC_ASSERT_NEXT(a_stage2_drains, done_s2, !vld_s2, "stage 2 refilled in the cycle it completed")

endmodule

FILE: tb/dfs_maze_carver_tb.sv
// Self-checking testbench for the depth-first maze carver: directed table, then random mazes.
`timescale 1ns / 1ps

module dfs_maze_carver_tb;
	import dmc_pkg::*;

	localparam int  MAXC       = DEF_MAX_COLUMNS;
	localparam int  MAXR       = DEF_MAX_ROWS;
	localparam int  CELLS      = MAXC * MAXR;
	localparam int  RANDOM_GOAL = 600;
	localparam int  DRAIN_WAIT = 8;		// extra wait after the last expected result is taken
	localparam time TIMEOUT_NS = 64'd2_400_000;	// far beyond the slowest run

	// One result item, field by field.
	typedef struct packed {
		ev_t             kind;
		logic [4:0]      col;
		logic [3:0]      row;
		logic [DIR_W-1:0] dir;
		logic            fin;
	} maze_event_t;

	// One row of the directed table: a register write or an input item.
	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] cfg_idx;
		logic [CFG_DATA_W-1:0]  cfg_val;
		logic                   act;
		logic [4:0]             oc;
		logic [3:0]             orw;
		logic [1:0]             p0;
		logic [1:0]             p1;
		logic [1:0]             p2;
		bit                     typed;
		maze_event_t            want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	dfs_maze_carver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Predictor state: a private copy of the registers, visited map and cell stack.
	int          cols_reg;
	int          rows_reg;
	bit          visited_cells [CELLS];
	logic [8:0]  stack_cells [CELLS];
	int          stack_fill;

	maze_event_t pending_events [$];	// expected results, oldest first
	plan_row_t   plan [$];

	int mismatches;
	int results_seen;
	int random_items;
	int burst_left;
	bit gaps_on;
	bit feeding;		// high while the random part keeps the input busy
	int n_start, n_carve, n_back, n_idle, n_done, n_settings;

	// Clock: 8 ns period.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Hard limit on the run.
	initial begin
		#(TIMEOUT_NS);
		$display("dfs_maze_carver_tb NOT OK");
		$finish;
	end

	function automatic int grid_span(input int reg_val, input int limit);
		if (reg_val == 0)
			return 1;
		if (reg_val > limit)
			return limit;
		return reg_val;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	// Append one row to the directed table.
	task automatic add_row(input plan_row_t row);
		plan = {plan, row};
	endtask

	// Predict the result of one accepted item and advance the private state.
	task automatic carve_predict(input logic act, input logic [4:0] oc, input logic [3:0] orw,
			input logic [1:0] p0, input logic [1:0] p1, input logic [1:0] p2,
			output maze_event_t ev);
		int         cols, rows, c, r, nc, nr, i, j, top, nidx;
		logic [1:0] dirs [4];
		logic [1:0] picks [3];
		logic [1:0] t;
		bit         ok, found;
		cols = grid_span(cols_reg, MAXC);
		rows = grid_span(rows_reg, MAXR);
		ev = '0;
		if (act == ACT_START) begin
			// Clamp the origin into the grid, then restart the map and the stack.
			c = (oc >= cols) ? cols - 1 : oc;
			r = (orw >= rows) ? rows - 1 : orw;
			foreach (visited_cells[k])
				visited_cells[k] = 1'b0;
			visited_cells[r * MAXC + c] = 1'b1;
			stack_cells[0] = 9'(r * MAXC + c);
			stack_fill = 1;
			ev.kind = EV_START;
			ev.col = 5'(c);
			ev.row = 4'(r);
		end else if (stack_fill == 0) begin
			ev.kind = EV_IDLE;
		end else begin
			top = stack_cells[stack_fill - 1];
			c = top % MAXC;
			r = top / MAXC;
			dirs[0] = DIR_UP;
			dirs[1] = DIR_RIGHT;
			dirs[2] = DIR_DOWN;
			dirs[3] = DIR_LEFT;
			picks[0] = p0;
			picks[1] = p1;
			picks[2] = p2;
			// Swap slot i with its pick; a pick below the slot leaves it in place.
			for (i = 0; i < 3; i++) begin
				j = (picks[i] < i) ? i : picks[i];
				t = dirs[i];
				dirs[i] = dirs[j];
				dirs[j] = t;
			end
			found = 1'b0;
			for (i = 0; i < 4 && !found; i++) begin
				nc = c;
				nr = r;
				case (dirs[i])
					DIR_UP: begin
						ok = r > 0;
						nr = r - 1;
					end
					DIR_RIGHT: begin
						ok = c + 1 < cols;
						nc = c + 1;
					end
					DIR_DOWN: begin
						ok = r + 1 < rows;
						nr = r + 1;
					end
					default: begin
						ok = c > 0;
						nc = c - 1;
					end
				endcase
				// Vertical moves test only the row, horizontal moves only the column.
				if (ok && (dirs[i] == DIR_UP || dirs[i] == DIR_DOWN) && nr >= rows)
					ok = 1'b0;
				if (ok && (dirs[i] == DIR_RIGHT || dirs[i] == DIR_LEFT) && nc >= cols)
					ok = 1'b0;
				if (ok) begin
					nidx = nr * MAXC + nc;
					if (!visited_cells[nidx] && stack_fill < CELLS) begin
						visited_cells[nidx] = 1'b1;
						stack_cells[stack_fill] = 9'(nidx);
						stack_fill++;
						found = 1'b1;
						ev.kind = EV_CARVE;
						ev.dir = dirs[i];
					end
				end
			end
			if (!found) begin
				stack_fill--;
				ev.kind = EV_BACKTRACK;
				ev.fin = (stack_fill == 0);
			end
			ev.col = 5'(c);
			ev.row = 4'(r);
		end
	endtask

	// Drop the input valid; n sets the length of the gap.
	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	// Sender bursts: after each burst insert a random gap, unless gaps are off.
	task automatic pace();
		if (gaps_on) begin
			if (burst_left == 0) begin
				hold_off($urandom_range(1, 6));
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
	endtask

	// Offer one item, wait for its acceptance, then record what it should produce.
	task automatic offer_item(input logic act, input logic [4:0] oc, input logic [3:0] orw,
			input logic [1:0] p0, input logic [1:0] p1, input logic [1:0] p2,
			input bit typed, input maze_event_t want);
		maze_event_t got;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {1'b0, p2, p1, p0, orw, oc};
		do
			@(posedge clk);
		while (!s_tready);
		carve_predict(act, oc, orw, p0, p1, p2, got);
		pending_events = {pending_events, typed ? want : got};
		case (got.kind)
			EV_START:     n_start++;
			EV_CARVE:     n_carve++;
			EV_BACKTRACK: n_back++;
			default:      n_idle++;
		endcase
		if (got.fin)
			n_done++;
	endtask

	// Wait until every expected result has left the block, plus its latency.
	task automatic drain();
		hold_off(1);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_COLUMNS_USED)
			cols_reg = val[COLS_REG_W-1:0];
		else
			rows_reg = val[ROWS_REG_W-1:0];
		n_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = val;
		return row;
	endfunction

	function automatic plan_row_t item_row(input logic act, input logic [4:0] oc,
			input logic [3:0] orw, input logic [1:0] p0, input logic [1:0] p1,
			input logic [1:0] p2);
		plan_row_t row;
		row = '{default: '0};
		row.act = act;
		row.oc = oc;
		row.orw = orw;
		row.p0 = p0;
		row.p1 = p1;
		row.p2 = p2;
		return row;
	endfunction

	// Attach a result that is obvious from the row itself.
	function automatic plan_row_t with_result(input plan_row_t row, input ev_t kind,
			input logic [4:0] col, input logic [3:0] r, input logic fin);
		row.typed = 1'b1;
		row.want = '0;
		row.want.kind = kind;
		row.want.col = col;
		row.want.row = r;
		row.want.fin = fin;
		return row;
	endfunction

	// Result checker: compare every taken result with the oldest expectation.
	maze_event_t seen_want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind=%0d tdata=%h last=%b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				seen_want = pending_events.pop_front();
				if (m_tuser !== seen_want.kind || m_tdata[4:0] !== seen_want.col ||
						m_tdata[8:5] !== seen_want.row || m_tdata[10:9] !== seen_want.dir ||
						m_tdata[15:11] !== '0 || m_tlast !== seen_want.fin)
					flag_mismatch($sformatf({"expected kind=%0d col=%0d row=%0d dir=%0d fin=%0d",
						" got kind=%0d col=%0d row=%0d dir=%0d fin=%0d pad=%h"},
						seen_want.kind, seen_want.col, seen_want.row, seen_want.dir,
						seen_want.fin, m_tuser, m_tdata[4:0], m_tdata[8:5], m_tdata[10:9],
						m_tlast, m_tdata[15:11]));
			end
		end
	end

	// Receiver: stall on a pattern picked at random for each stretch, and twice
	// hold off for a long stretch while the sender keeps offering items.
	initial begin
		int stretch, mode, hold, presses;
		m_tready = 1'b0;
		stretch = 0;
		mode = 0;
		hold = 0;
		presses = 0;
		forever begin
			@(negedge clk);
			if (hold == 0 && presses < 2 && feeding && results_seen >= 150 * (presses + 1)) begin
				hold = 120;
				presses++;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(16, 96);
				end
				stretch--;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (stretch % 3 == 0);
				endcase
			end
		end
	end

	// Stimulus: reset, directed table, random mazes, then drain and report.
	initial begin
		int          mazes, steps, cap, cells, pick;
		logic [5:0]  cols_val, rows_val;
		maze_event_t none;

		none = '0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_START;
		mismatches = 0;
		results_seen = 0;
		random_items = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		feeding = 1'b0;
		n_start = 0;
		n_carve = 0;
		n_back = 0;
		n_idle = 0;
		n_done = 0;
		n_settings = 0;
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;
		stack_fill = 0;
		foreach (visited_cells[k])
			visited_cells[k] = 1'b0;

		// Directed table. Reset grid is 10 x 7.
		// Step before any start: ignored.
		add_row(with_result(item_row(ACT_STEP, 5'd0, 4'd0, 2'd0, 2'd1, 2'd2),
			EV_IDLE, 5'd0, 4'd0, 1'b0));
		// Origin beyond the grid saturates to the far corner.
		add_row(with_result(item_row(ACT_START, 5'd31, 4'd15, 2'd0, 2'd0, 2'd0),
			EV_START, 5'd9, 4'd6, 1'b0));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd0, 2'd1, 2'd2));
		add_row(item_row(ACT_STEP, 5'd31, 4'd15, 2'd3, 2'd3, 2'd3));
		// Picks below their slots: no swap.
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd0, 2'd0, 2'd0));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd2, 2'd1, 2'd3));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd1, 2'd2, 2'd1));
		// Start while carving drops the running maze.
		add_row(with_result(item_row(ACT_START, 5'd0, 4'd0, 2'd3, 2'd3, 2'd3),
			EV_START, 5'd0, 4'd0, 1'b0));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd3, 2'd1, 2'd2));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd0, 2'd3, 2'd2));
		// Single-cell grid: start, immediate final backtrack, then idle.
		add_row(cfg_row(REG_COLUMNS_USED, 6'd1));
		add_row(cfg_row(REG_ROWS_USED, 6'd1));
		add_row(with_result(item_row(ACT_START, 5'd5, 4'd5, 2'd0, 2'd0, 2'd0),
			EV_START, 5'd0, 4'd0, 1'b0));
		add_row(with_result(item_row(ACT_STEP, 5'd0, 4'd0, 2'd2, 2'd3, 2'd3),
			EV_BACKTRACK, 5'd0, 4'd0, 1'b1));
		add_row(with_result(item_row(ACT_STEP, 5'd31, 4'd15, 2'd3, 2'd3, 2'd3),
			EV_IDLE, 5'd0, 4'd0, 1'b0));
		// Zero sizes act as one.
		add_row(cfg_row(REG_COLUMNS_USED, 6'd0));
		add_row(cfg_row(REG_ROWS_USED, 6'd0));
		add_row(with_result(item_row(ACT_START, 5'd31, 4'd15, 2'd1, 2'd1, 2'd1),
			EV_START, 5'd0, 4'd0, 1'b0));
		add_row(with_result(item_row(ACT_STEP, 5'd0, 4'd0, 2'd0, 2'd1, 2'd2),
			EV_BACKTRACK, 5'd0, 4'd0, 1'b1));
		// Oversized registers act as the full 32 x 16 grid.
		add_row(cfg_row(REG_COLUMNS_USED, 6'd63));
		add_row(cfg_row(REG_ROWS_USED, 6'd63));
		add_row(with_result(item_row(ACT_START, 5'd31, 4'd15, 2'd0, 2'd0, 2'd0),
			EV_START, 5'd31, 4'd15, 1'b0));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd1, 2'd1, 2'd2));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd2, 2'd3, 2'd3));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd3, 2'd2, 2'd3));
		add_row(with_result(item_row(ACT_START, 5'd0, 4'd15, 2'd0, 2'd0, 2'd0),
			EV_START, 5'd0, 4'd15, 1'b0));
		// Two-cell grid: run a whole maze to its end.
		add_row(cfg_row(REG_COLUMNS_USED, 6'd2));
		add_row(cfg_row(REG_ROWS_USED, 6'd1));
		add_row(with_result(item_row(ACT_START, 5'd1, 4'd0, 2'd0, 2'd0, 2'd0),
			EV_START, 5'd1, 4'd0, 1'b0));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd1, 2'd1, 2'd2));
		add_row(item_row(ACT_STEP, 5'd0, 4'd0, 2'd0, 2'd1, 2'd2));
		add_row(with_result(item_row(ACT_STEP, 5'd0, 4'd0, 2'd3, 2'd2, 2'd2),
			EV_BACKTRACK, 5'd1, 4'd0, 1'b1));

		// Hold reset, then release it between edges.
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				write_reg(plan[k].cfg_idx, plan[k].cfg_val);
			end else begin
				pace();
				offer_item(plan[k].act, plan[k].oc, plan[k].orw, plan[k].p0, plan[k].p1,
					plan[k].p2, plan[k].typed, plan[k].want);
			end
		end

		// Random part: per setting, a few mazes carved mostly to completion.
		while (random_items < RANDOM_GOAL) begin
			feeding = 1'b0;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				cols_val = 6'($urandom_range(1, 8));
				rows_val = 6'($urandom_range(1, 6));
			end else if (pick < 9) begin
				cols_val = 6'($urandom_range(0, 63));
				rows_val = 6'($urandom_range(0, 63));
			end else begin
				case ($urandom_range(0, 3))
					0:       cols_val = 6'd0;
					1:       cols_val = 6'd1;
					2:       cols_val = 6'd32;
					default: cols_val = 6'd63;
				endcase
				case ($urandom_range(0, 3))
					0:       rows_val = 6'd0;
					1:       rows_val = 6'd1;
					2:       rows_val = 6'd16;
					default: rows_val = 6'd31;
				endcase
			end
			write_reg(REG_COLUMNS_USED, cols_val);
			write_reg(REG_ROWS_USED, rows_val);
			cells = grid_span(cols_reg, MAXC) * grid_span(rows_reg, MAXR);
			gaps_on = ($urandom_range(0, 9) >= 3);
			feeding = 1'b1;
			mazes = $urandom_range(2, 4);
			repeat (mazes) begin
				// Noise: steps while idle.
				if (stack_fill == 0 && $urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 2)) begin
						pace();
						offer_item(ACT_STEP, 5'($urandom_range(0, 31)),
							4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
							2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
							1'b0, none);
					end
				end
				pace();
				offer_item(ACT_START, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), 1'b0, none);
				random_items++;
				// Large grids are cut short; the next start drops them mid-carve.
				cap = (cells > 48) ? $urandom_range(60, 160) : 4 * CELLS;
				steps = 0;
				while (stack_fill > 0 && steps < cap) begin
					if ($urandom_range(0, 99) < 3)
						break;
					pace();
					offer_item(ACT_STEP, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
						2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)), 1'b0, none);
					random_items++;
					steps++;
				end
			end
		end

		// Wind down: stop offering, wait for the last results and a little longer.
		feeding = 1'b0;
		hold_off(1);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		$display("covered %0d register settings, %0d starts, %0d carves, %0d backtracks",
			n_settings, n_start, n_carve, n_back);
		$display("%0d mazes carved to the end, %0d idle steps, %0d results, %0d mismatches",
			n_done, n_idle, results_seen, mismatches);
		if (mismatches == 0) begin
			$display("dfs_maze_carver_tb OK");
		end else begin
			$display("dfs_maze_carver_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: dfs_maze_carver.f
+incdir+rtl
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/dmc_pick.sv
rtl/dfs_maze_carver.sv
tb/dfs_maze_carver_tb.sv
